@@ sv/apc_pkg.sv @@
// Shared types, constants and the control program of the admittance position controller.
// Used by apc_sequencer, apc_datapath and admittance_position_controller; no dependencies.
package apc_pkg;

    localparam int DW       = 32;
    localparam int TEND_W   = 31;
    localparam int NUM_REGS = 8;
    localparam int REG_IW   = 3;
    localparam int FRAC     = 16;
    localparam int PROD_W   = 2 * DW;
    localparam int ACC_W    = PROD_W - FRAC + 2;
    localparam int SUB_W    = ACC_W + 2;
    localparam int PC_W     = 4;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 96;

    // Configuration register indexes; the multiplier coefficient select uses them directly.
    localparam logic [REG_IW-1:0] REG_A11 = 3'd0;
    localparam logic [REG_IW-1:0] REG_A12 = 3'd1;
    localparam logic [REG_IW-1:0] REG_A21 = 3'd2;
    localparam logic [REG_IW-1:0] REG_A22 = 3'd3;
    localparam logic [REG_IW-1:0] REG_B1  = 3'd4;
    localparam logic [REG_IW-1:0] REG_B2  = 3'd5;
    localparam logic [REG_IW-1:0] REG_GP  = 3'd6;
    localparam logic [REG_IW-1:0] REG_GD  = 3'd7;

    // Subtractor A operand.
    localparam logic [2:0] A_ZERO = 3'd0;
    localparam logic [2:0] A_TP   = 3'd1;
    localparam logic [2:0] A_TV   = 3'd2;
    localparam logic [2:0] A_NP   = 3'd3;
    localparam logic [2:0] A_NV   = 3'd4;
    localparam logic [2:0] A_ACC  = 3'd5;

    // Subtractor B operand.
    localparam logic [2:0] B_ZERO = 3'd0;
    localparam logic [2:0] B_AP   = 3'd1;
    localparam logic [2:0] B_AV   = 3'd2;
    localparam logic [2:0] B_MP   = 3'd3;
    localparam logic [2:0] B_MV   = 3'd4;
    localparam logic [2:0] B_ACC  = 3'd5;

    // Subtractor destination.
    localparam logic [2:0] D_NONE = 3'd0;
    localparam logic [2:0] D_EP   = 3'd1;
    localparam logic [2:0] D_EV   = 3'd2;
    localparam logic [2:0] D_NP   = 3'd3;
    localparam logic [2:0] D_NV   = 3'd4;
    localparam logic [2:0] D_DT   = 3'd5;
    localparam logic [2:0] D_PE   = 3'd6;

    // Multiplier data operand.
    localparam logic [2:0] MB_EP  = 3'd0;
    localparam logic [2:0] MB_EV  = 3'd1;
    localparam logic [2:0] MB_MF  = 3'd2;
    localparam logic [2:0] MB_PE  = 3'd3;
    localparam logic [2:0] MB_DT  = 3'd4;

    // Accumulator operation.
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // Jump condition.
    localparam logic [1:0] J_NONE   = 2'd0;
    localparam logic [1:0] J_ALWAYS = 2'd1;
    localparam logic [1:0] J_FREE   = 2'd2;

    typedef struct packed {
        logic [2:0]      sub_a;
        logic [2:0]      sub_b;
        logic [2:0]      sub_dst;
        logic            mul_en;
        logic [REG_IW-1:0] mul_coef;
        logic [2:0]      mul_b;
        logic [1:0]      acc_op;
        logic            clamp_en;
        logic [1:0]      jmp;
        logic [PC_W-1:0] jmp_target;
        logic            done;
    } ctrl_t;

    typedef struct packed {
        ctrl_t word;
        logic  step_en;
        logic  start;
    } seq_ctl_t;

    typedef logic [NUM_REGS-1:0][DW-1:0] coef_set_t;

    // Control program. The multiplier result is registered, so the accumulator
    // picks up a product one step after it was issued.
    function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '0;
        w.sub_dst = D_NONE;
        w.acc_op  = ACC_HOLD;
        w.jmp     = J_NONE;
        case (pc)
            4'd0: begin
                w.sub_a = A_TP; w.sub_b = B_AP; w.sub_dst = D_EP;
            end
            4'd1: begin
                w.sub_a = A_TV; w.sub_b = B_AV; w.sub_dst = D_EV;
                w.mul_en = 1'b1; w.mul_coef = REG_A11; w.mul_b = MB_EP;
            end
            4'd2: begin
                w.mul_en = 1'b1; w.mul_coef = REG_A12; w.mul_b = MB_EV;
                w.acc_op = ACC_LOAD;
            end
            4'd3: begin
                w.mul_en = 1'b1; w.mul_coef = REG_B1; w.mul_b = MB_MF;
                w.acc_op = ACC_ADD;
            end
            4'd4: begin
                w.mul_en = 1'b1; w.mul_coef = REG_A21; w.mul_b = MB_EP;
                w.acc_op = ACC_ADD;
            end
            4'd5: begin
                w.sub_a = A_TP; w.sub_b = B_ACC; w.sub_dst = D_NP;
                w.mul_en = 1'b1; w.mul_coef = REG_A22; w.mul_b = MB_EV;
                w.acc_op = ACC_LOAD;
            end
            4'd6: begin
                w.mul_en = 1'b1; w.mul_coef = REG_B2; w.mul_b = MB_MF;
                w.acc_op = ACC_ADD;
            end
            4'd7: begin
                w.acc_op = ACC_ADD;
            end
            4'd8: begin
                w.sub_a = A_TV; w.sub_b = B_ACC; w.sub_dst = D_NV;
                w.jmp = J_FREE; w.jmp_target = 4'd10;
            end
            4'd9: begin
                w.clamp_en = 1'b1;
                w.sub_a = A_ZERO; w.sub_b = B_MV; w.sub_dst = D_DT;
                w.jmp = J_ALWAYS; w.jmp_target = 4'd11;
            end
            4'd10: begin
                w.sub_a = A_NV; w.sub_b = B_MV; w.sub_dst = D_DT;
            end
            4'd11: begin
                w.sub_a = A_NP; w.sub_b = B_MP; w.sub_dst = D_PE;
            end
            4'd12: begin
                w.mul_en = 1'b1; w.mul_coef = REG_GP; w.mul_b = MB_PE;
            end
            4'd13: begin
                w.mul_en = 1'b1; w.mul_coef = REG_GD; w.mul_b = MB_DT;
                w.acc_op = ACC_LOAD;
            end
            4'd14: begin
                w.acc_op = ACC_ADD;
            end
            4'd15: begin
                w.sub_a = A_ACC; w.sub_b = B_ZERO; w.done = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // Saturation of a subtractor result to the 32-bit signed range.
    function automatic logic sat_ovf(input logic signed [SUB_W-1:0] v);
        return (v > SUB_W'(signed'(32'sh7FFFFFFF))) ||
               (v < SUB_W'(signed'(32'sh80000000)));
    endfunction

    function automatic logic [DW-1:0] sat32(input logic signed [SUB_W-1:0] v);
        logic [DW-1:0] r;
        if (v > SUB_W'(signed'(32'sh7FFFFFFF))) begin
            r = 32'h7FFFFFFF;
        end else if (v < SUB_W'(signed'(32'sh80000000))) begin
            r = 32'h80000000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/apc_sequencer.sv @@
// Step counter and program ROM of the admittance position controller.
// Depends on apc_pkg; drives apc_datapath through a seq_ctl_t bundle.
module apc_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             free_mode,
    input  logic             out_free,
    output apc_pkg::seq_ctl_t ctl
);
    import apc_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_t           word;
    logic            step_en;
    logic            start;

    always_comb begin
        word     = prog_word(pc_reg);
        // The last step waits while the output register still holds an untaken word.
        step_en  = busy_reg && !(word.done && !out_free);
        start    = s_tvalid && !busy_reg;
        s_tready = !busy_reg;

        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = '0;
        end else if (step_en) begin
            if (word.done) begin
                busy_next = 1'b0;
                pc_next   = '0;
            end else if (word.jmp == J_ALWAYS || (word.jmp == J_FREE && free_mode)) begin
                pc_next = word.jmp_target;
            end else begin
                pc_next = pc_reg + PC_W'(1);
            end
        end

        ctl.word    = word;
        ctl.step_en = step_en;
        ctl.start   = start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

@@ sv/apc_datapath.sv @@
// Datapath of the admittance position controller: saturating subtractor, one
// 32x32 multiplier, accumulator, working registers and the stored admittance state.
// Depends on apc_pkg; controlled by apc_sequencer.
module apc_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  apc_pkg::seq_ctl_t         ctl,
    input  apc_pkg::coef_set_t        coefs,
    input  logic [apc_pkg::DW-1:0]    meas_position,
    input  logic [apc_pkg::DW-1:0]    meas_velocity,
    input  logic [apc_pkg::DW-1:0]    meas_force,
    input  logic [apc_pkg::DW-1:0]    target_position,
    input  logic [apc_pkg::DW-1:0]    target_velocity,
    input  logic [apc_pkg::TEND_W-1:0] travel_end,
    input  logic                      free_mode_in,
    output logic                      free_mode,
    output logic                      res_valid,
    output logic [apc_pkg::DW-1:0]    drive_command,
    output logic [apc_pkg::DW-1:0]    adm_position_out,
    output logic [apc_pkg::DW-1:0]    adm_velocity_out,
    output logic                      clamped
);
    import apc_pkg::*;

    // Captured input word.
    logic [DW-1:0]     mp_reg, mv_reg, mf_reg, tp_reg, tv_reg;
    logic [TEND_W-1:0] tend_reg;
    logic              free_reg;

    // Working registers.
    logic [DW-1:0] ep_reg, ev_reg, np_reg, nv_reg, dt_reg, pe_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic flag_reg, flag_next;
    logic [DW-1:0] adm_p_reg, adm_v_reg;

    logic signed [SUB_W-1:0] op_a, op_b, diff;
    logic [DW-1:0]           diff_sat;
    logic                    diff_ovf;
    logic [DW-1:0]           mul_a, mul_b;
    logic signed [ACC_W-1:0] prod_q;
    logic [DW-1:0]           np_clamp;
    logic                    clamp_hit;
    ctrl_t                   w;

    always_comb begin
        w = ctl.word;

        case (w.sub_a)
            A_TP:    op_a = SUB_W'(signed'(tp_reg));
            A_TV:    op_a = SUB_W'(signed'(tv_reg));
            A_NP:    op_a = SUB_W'(signed'(np_reg));
            A_NV:    op_a = SUB_W'(signed'(nv_reg));
            A_ACC:   op_a = SUB_W'(acc_reg);
            default: op_a = '0;
        endcase
        case (w.sub_b)
            B_AP:    op_b = SUB_W'(signed'(adm_p_reg));
            B_AV:    op_b = SUB_W'(signed'(adm_v_reg));
            B_MP:    op_b = SUB_W'(signed'(mp_reg));
            B_MV:    op_b = SUB_W'(signed'(mv_reg));
            B_ACC:   op_b = SUB_W'(acc_reg);
            default: op_b = '0;
        endcase
        diff     = op_a - op_b;
        diff_sat = sat32(diff);
        diff_ovf = sat_ovf(diff);

        mul_a = coefs[w.mul_coef];
        case (w.mul_b)
            MB_EP:   mul_b = ep_reg;
            MB_EV:   mul_b = ev_reg;
            MB_MF:   mul_b = mf_reg;
            MB_PE:   mul_b = pe_reg;
            MB_DT:   mul_b = dt_reg;
            default: mul_b = '0;
        endcase

        // Dropping the fraction bits of the product rounds toward minus infinity.
        prod_q = ACC_W'(signed'(prod_reg[PROD_W-1:FRAC]));
        case (w.acc_op)
            ACC_LOAD: acc_next = prod_q;
            ACC_ADD:  acc_next = acc_reg + prod_q;
            default:  acc_next = acc_reg;
        endcase

        // Raise to zero first, then lower to the travel end.
        clamp_hit = 1'b0;
        np_clamp  = np_reg;
        if (np_reg[DW-1]) begin
            np_clamp  = '0;
            clamp_hit = 1'b1;
        end else if (np_reg > {1'b0, tend_reg}) begin
            np_clamp  = {1'b0, tend_reg};
            clamp_hit = 1'b1;
        end

        flag_next = flag_reg;
        if ((w.sub_dst != D_NONE || w.done) && diff_ovf) begin
            flag_next = 1'b1;
        end
        if (w.clamp_en && clamp_hit) begin
            flag_next = 1'b1;
        end

        free_mode        = free_reg;
        res_valid        = ctl.step_en && w.done;
        drive_command    = diff_sat;
        adm_position_out = np_reg;
        adm_velocity_out = nv_reg;
        clamped          = flag_next;
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            mp_reg   <= meas_position;
            mv_reg   <= meas_velocity;
            mf_reg   <= meas_force;
            tp_reg   <= target_position;
            tv_reg   <= target_velocity;
            tend_reg <= travel_end;
            free_reg <= free_mode_in;
        end
        if (ctl.step_en) begin
            case (w.sub_dst)
                D_EP:    ep_reg <= diff_sat;
                D_EV:    ev_reg <= diff_sat;
                D_NP:    np_reg <= diff_sat;
                D_NV:    nv_reg <= diff_sat;
                D_DT:    dt_reg <= diff_sat;
                D_PE:    pe_reg <= diff_sat;
                default: ;
            endcase
            if (w.clamp_en) begin
                np_reg <= np_clamp;
            end
            if (w.mul_en) begin
                prod_reg <= signed'(mul_a) * signed'(mul_b);
            end
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg  <= 1'b0;
            adm_p_reg <= '0;
            adm_v_reg <= '0;
        end else begin
            if (ctl.start) begin
                flag_reg <= 1'b0;
            end else if (ctl.step_en) begin
                flag_reg <= flag_next;
            end
            if (res_valid) begin
                adm_p_reg <= np_reg;
                adm_v_reg <= nv_reg;
            end
        end
    end

endmodule

@@ sv/admittance_position_controller.sv @@
// Top level of the admittance position controller: configuration registers,
// output register, and the microcoded sequencer with its datapath.
// Depends on apc_pkg, apc_sequencer and apc_datapath.
//
//  Channel   Direction  Handshake           Contents
//  s_        in         s_tvalid/s_tready   measurements, targets, travel end; mode in tuser
//  m_        out        m_tvalid/m_tready   drive command, admittance state; flag in tuser
//  cfg_      in         cfg_we              coefficient and gain registers, index 0 to 7
//
// Each word is captured and then worked through the program steps in turn, as set by the
// single shared multiplier and subtractor that the control program sequences.
// The program holds 16 steps, but the mode branch runs only one of its two arms.
// Reset is synchronous and active low; it clears the sequencer, the admittance
// state and the output valid, while coefficients reset to zero.
// A finished result waits in the output register, so the next word is taken
// and worked on meanwhile; only the final step waits if that register is still full.
module admittance_position_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input word.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: meas_position, meas_velocity, meas_force, target_position,
    // target_velocity, travel_end (31 bits), one zero pad bit.
    input  logic [apc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tuser: free_mode.
    input  logic [0:0]                        s_tuser,
    // Result word.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: drive_command, adm_position_out, adm_velocity_out.
    output logic [apc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // tuser: clamped.
    output logic [0:0]                        m_tuser,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [apc_pkg::REG_IW-1:0]        cfg_addr,
    input  logic [apc_pkg::DW-1:0]            cfg_wdata
);
    import apc_pkg::*;

    coef_set_t coef_reg;
    seq_ctl_t  ctl;
    logic      free_mode;
    logic      out_free;
    logic      res_valid;
    logic [DW-1:0] res_cmd, res_pos, res_vel;
    logic      res_flag;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_flag_reg;

    // Software must load the coefficient registers only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_we) begin
            coef_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    apc_sequencer u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .free_mode (free_mode),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    apc_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .coefs            (coef_reg),
        .meas_position    (s_tdata[31:0]),
        .meas_velocity    (s_tdata[63:32]),
        .meas_force       (s_tdata[95:64]),
        .target_position  (s_tdata[127:96]),
        .target_velocity  (s_tdata[159:128]),
        .travel_end       (s_tdata[190:160]),
        .free_mode_in     (s_tuser[0]),
        .free_mode        (free_mode),
        .res_valid        (res_valid),
        .drive_command    (res_cmd),
        .adm_position_out (res_pos),
        .adm_velocity_out (res_vel),
        .clamped          (res_flag)
    );

    // Output register: loaded on the final program step, which only runs when
    // the register is empty or being emptied in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= {res_vel, res_pos, res_cmd};
            m_flag_reg <= res_flag;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_flag_reg;

endmodule
